/* hw/rtl/sfr_pkg.sv */
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

   // Field widths
   localparam int OPCODE_W  = 1;
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 6;
   localparam int LENGTH_W  = 7;
   localparam int PERCENT_W = 7;

   // Default payload store depth
   localparam int MAX_PAYLOAD_DEFAULT = 64;

   // Item opcodes
   localparam logic [OPCODE_W-1:0] OPCODE_RX   = 1'b0;
   localparam logic [OPCODE_W-1:0] OPCODE_READ = 1'b1;

   // Tag register value out of reset
   localparam logic [BYTE_W-1:0] TAG_RESET = 8'hFF;

   // Varint length decoding
   localparam int GROUP_W        = 3;
   localparam int GROUP_BITS     = 7;
   localparam int SUMMED_GROUPS  = 2;  // groups past this must carry zero
   localparam int LAST_GROUP     = 7;  // no continuation after the eighth group
   localparam int LEN_SUM_W      = 15; // wide enough for a shifted group plus length

   // Success rate window
   localparam int TALLY_W         = 4;
   localparam int FRAMES_PER_RATE = 10;

   // Queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // Item as held in the queue, with classification done at the front
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  read_index;
      logic                is_tag;
      logic                is_zero;
   } sfr_item_type;

endpackage

/* hw/rtl/sfr_if.sv */
// Request and response channel interfaces of the stuffed frame receiver.
interface sfr_req_if;
   import sfr_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   rx_byte;
   logic [INDEX_W-1:0]  read_index;

   modport source (output valid, output opcode, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input opcode, input rx_byte, input read_index,
                 output ready);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 frame_good;
   logic                 frame_error;
   logic [BYTE_W-1:0]    frame_ident;
   logic [LENGTH_W-1:0]  frame_length;
   logic [BYTE_W-1:0]    payload_byte;
   logic [PERCENT_W-1:0] success_percent;

   modport source (output valid, output frame_good, output frame_error,
                   output frame_ident, output frame_length, output payload_byte,
                   output success_percent, input ready);
   modport sink (input valid, input frame_good, input frame_error,
                 input frame_ident, input frame_length, input payload_byte,
                 input success_percent, output ready);
endinterface

/* hw/rtl/sfr_front.sv */
// Front end: accepts items, classifies link bytes against the tag and queues them.
module sfr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sfr_pkg::BYTE_W-1:0]   tag_byte,
   sfr_req_if.sink                      req,
   output logic                         item_valid,
   output sfr_pkg::sfr_item_type        item,
   input  logic                         item_pop
);
   import sfr_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   sfr_item_type        queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PW:0]         count_ff, count_in;
   logic                push;
   sfr_item_type        incoming;

   // Classify the incoming byte
   always_comb begin
      incoming.opcode     = req.opcode;
      incoming.rx_byte    = req.rx_byte;
      incoming.read_index = req.read_index;
      incoming.is_tag     = (req.rx_byte == tag_byte);
      incoming.is_zero    = (req.rx_byte == '0);
   end

   assign req.ready  = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign push       = req.valid & req.ready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, item_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

/* hw/rtl/sfr_back.sv */
// Back end: frame parser, payload store, success rate and result register.
module sfr_back #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  sfr_pkg::sfr_item_type item,
   output logic                  item_pop,
   sfr_rsp_if.source             rsp
);
   import sfr_pkg::*;

   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;

   // Parser phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   logic [2:0]           phase_ff, phase_in;
   logic                 after_tag_ff, after_tag_in;
   logic [BYTE_W-1:0]    ident_ff, ident_in;
   logic [LW-1:0]        length_ff, length_in;
   logic [GROUP_W-1:0]   group_ff, group_in;
   logic [LW-1:0]        byte_pos_ff, byte_pos_in;
   logic [BYTE_W-1:0]    sum_ff, sum_in;
   logic [TALLY_W-1:0]   good_tally_ff, good_tally_in;
   logic [TALLY_W-1:0]   bad_tally_ff, bad_tally_in;
   logic [PERCENT_W-1:0] rate_ff, rate_in;
   logic                 rsp_valid_ff;

   logic [BYTE_W-1:0]    store_mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_ok_ff;
   logic                 good_ff, error_ff;

   logic                 advance;
   logic                 is_rx;
   logic                 good, bad;
   logic [2:0]           ph;
   logic                 at;
   logic [GROUP_W-1:0]   grp;
   logic [LW-1:0]        bpos;
   logic [BYTE_W-1:0]    rsum;
   logic [GROUP_BITS-1:0] group_val;
   logic [2*GROUP_BITS-1:0] group_shifted;
   logic [LEN_SUM_W-1:0] len_sum;
   logic [LW-1:0]        len_tmp;
   logic [LW:0]          bpos_inc;
   logic [TALLY_W:0]     tally_total;
   logic                 store_we;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic                 rd_ok;

   assign advance  = !rsp_valid_ff || rsp.ready;
   assign item_pop = item_valid && advance;
   assign is_rx    = item_pop && (item.opcode == OPCODE_RX);

   assign group_val     = item.rx_byte[GROUP_BITS-1:0];
   assign group_shifted = grp[0] ? {group_val, {GROUP_BITS{1'b0}}}
                                 : {{GROUP_BITS{1'b0}}, group_val};
   assign len_sum       = LEN_SUM_W'(group_shifted) + LEN_SUM_W'(length_ff);
   assign bpos_inc      = {1'b0, bpos} + {{LW{1'b0}}, 1'b1};

   // Step the parser for one link byte
   always_comb begin
      phase_in      = phase_ff;
      after_tag_in  = after_tag_ff;
      ident_in      = ident_ff;
      length_in     = length_ff;
      group_in      = group_ff;
      byte_pos_in   = byte_pos_ff;
      sum_in        = sum_ff;
      good_tally_in = good_tally_ff;
      bad_tally_in  = bad_tally_ff;
      rate_in       = rate_ff;
      good          = 1'b0;
      bad           = 1'b0;
      store_we      = 1'b0;
      len_tmp       = length_ff;
      tally_total   = '0;
      ph            = phase_ff;
      at            = after_tag_ff;
      grp           = group_ff;
      bpos          = byte_pos_ff;
      rsum          = sum_ff;

      if (is_rx) begin
         // A finished frame restarts the hunt on the next byte
         if (ph == PH_DONE) begin
            ph           = PH_HUNT;
            at           = 1'b0;
            grp          = '0;
            bpos         = '0;
            rsum         = '0;
            after_tag_in = 1'b0;
            group_in     = '0;
            byte_pos_in  = '0;
            sum_in       = '0;
         end

         if (ph != PH_ID && ph != PH_LEN && ph != PH_DATA && ph != PH_CRC) begin
            // Hunt for a tag pair
            phase_in = PH_HUNT;
            if (!item.is_tag) begin
               after_tag_in = 1'b0;
            end else if (at) begin
               phase_in     = PH_ID;
               after_tag_in = 1'b0;
               length_in    = '0;
            end else begin
               after_tag_in = 1'b1;
            end
         end else if (at) begin
            // Drop the stuffed zero after a data tag
            if (item.is_zero) begin
               after_tag_in = 1'b0;
            end else begin
               bad = 1'b1;
            end
         end else begin
            if (item.is_tag) begin
               after_tag_in = 1'b1;
            end
            case (ph)
               PH_ID: begin
                  sum_in   = rsum + item.rx_byte;
                  ident_in = item.rx_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  sum_in = rsum + item.rx_byte;
                  if (group_val != '0) begin
                     if (grp >= GROUP_W'(SUMMED_GROUPS)) begin
                        bad = 1'b1;
                     end else if (len_sum > LEN_SUM_W'(MAX_PAYLOAD)) begin
                        bad = 1'b1;
                     end else begin
                        len_tmp = LW'(len_sum);
                     end
                  end
                  if (!bad) begin
                     length_in = len_tmp;
                     if (!item.rx_byte[BYTE_W-1]) begin
                        phase_in = (len_tmp == '0) ? PH_CRC : PH_DATA;
                     end else if (grp >= GROUP_W'(LAST_GROUP)) begin
                        bad = 1'b1;
                     end else begin
                        group_in = grp + 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  sum_in   = rsum + item.rx_byte;
                  store_we = 1'b1;
                  if (bpos_inc >= {1'b0, length_ff}) begin
                     phase_in    = PH_CRC;
                     byte_pos_in = '0;
                  end else begin
                     byte_pos_in = LW'(bpos_inc);
                  end
               end
               default: begin
                  // Checksum byte
                  if (item.rx_byte != rsum) begin
                     bad = 1'b1;
                  end else begin
                     good          = 1'b1;
                     phase_in      = PH_DONE;
                     good_tally_in = good_tally_ff + 1'b1;
                  end
               end
            endcase
         end

         // Abort the frame
         if (bad) begin
            bad_tally_in = bad_tally_ff + 1'b1;
            phase_in     = PH_HUNT;
            after_tag_in = 1'b0;
            group_in     = '0;
            byte_pos_in  = '0;
            sum_in       = '0;
            length_in    = '0;
         end

         // Latch the success rate every ten frames
         tally_total = {1'b0, good_tally_in} + {1'b0, bad_tally_in};
         if (tally_total >= (TALLY_W+1)'(FRAMES_PER_RATE)) begin
            rate_in       = PERCENT_W'({good_tally_in, 3'b000})
                          + PERCENT_W'({good_tally_in, 1'b0});
            good_tally_in = '0;
            bad_tally_in  = '0;
         end
      end
   end

   // Payload read follows the state after this item
   assign wr_addr = AW'(byte_pos_ff);
   assign rd_addr = AW'(item.read_index);
   assign rd_ok   = (CW'(item.read_index) < CW'(length_in))
                 && (CW'(item.read_index) < CW'(MAX_PAYLOAD));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         after_tag_ff  <= 1'b0;
         ident_ff      <= '0;
         length_ff     <= '0;
         group_ff      <= '0;
         byte_pos_ff   <= '0;
         sum_ff        <= '0;
         good_tally_ff <= '0;
         bad_tally_ff  <= '0;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         after_tag_ff  <= after_tag_in;
         ident_ff      <= ident_in;
         length_ff     <= length_in;
         group_ff      <= group_in;
         byte_pos_ff   <= byte_pos_in;
         sum_ff        <= sum_in;
         good_tally_ff <= good_tally_in;
         bad_tally_ff  <= bad_tally_in;
         rate_ff       <= rate_in;
         if (advance) begin
            rsp_valid_ff <= item_valid;
         end
      end
   end

   // Write the payload store and register the read, forwarding a same-cycle write
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_addr] <= item.rx_byte;
      end
      if (item_pop) begin
         rd_data_ff <= (store_we && wr_addr == rd_addr) ? item.rx_byte : store_mem[rd_addr];
         rd_ok_ff   <= rd_ok;
         good_ff    <= good;
         error_ff   <= bad;
      end
   end

   // Parser state changes only with a new result, so it drives the result directly
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.frame_good      = good_ff;
   assign rsp.frame_error     = error_ff;
   assign rsp.frame_ident     = ident_ff;
   assign rsp.frame_length    = LENGTH_W'(length_ff);
   assign rsp.payload_byte    = rd_ok_ff ? rd_data_ff : '0;
   assign rsp.success_percent = rate_ff;

endmodule

/* hw/rtl/stuffed_frame_receiver.sv */
// Top level of the stuffed frame receiver: tag register, front end, queue and parser.
// Takes one item per cycle while the response side is ready, and gives one result per
// item, in order. An accepted item lands in a two-entry queue at the front, where its
// byte is compared with the tag; the parser pops it from the queue when the response
// side is ready and registers the result. Payload bytes go to a store of MAX_PAYLOAD
// entries with one write and one registered read per cycle; entries never written since
// reset read back as unknown. The tag register may be written only while no item is in
// flight.
module stuffed_frame_receiver #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [sfr_pkg::BYTE_W-1:0] csr_wr_data,
   sfr_req_if.sink                    req,
   sfr_rsp_if.source                  rsp
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] tag_byte_ff;
   logic              item_valid;
   logic              item_pop;
   sfr_item_type      item;

   // Hold the tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_byte_ff <= TAG_RESET;
      end else if (csr_wr_en) begin
         tag_byte_ff <= csr_wr_data;
      end
   end

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .tag_byte   (tag_byte_ff),
      .req        (req),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   sfr_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp        (rsp)
   );

   // A result never both completes and aborts a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.frame_good && rsp.frame_error))
      else $error("frame_good and frame_error both set");

   // A queued item stays queued until the parser takes it
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && !item_pop) |=> item_valid)
      else $error("queued item lost");

   // The success rate stays within a percentage
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.success_percent <= PERCENT_W'(100)))
      else $error("success_percent above 100");

endmodule

/* tb/stuffed_frame_receiver_tb.sv */
// Self-checking testbench for the stuffed frame receiver: framed link traffic against a predictor.
`timescale 1ns / 1ps

module stuffed_frame_receiver_tb;
   import sfr_pkg::*;

   localparam int PAYLOAD_DEPTH = MAX_PAYLOAD_DEFAULT;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   rx_byte;
      logic [INDEX_W-1:0]  read_index;
   } link_item_type;

   typedef struct packed {
      logic                 frame_good;
      logic                 frame_error;
      logic [BYTE_W-1:0]    frame_ident;
      logic [LENGTH_W-1:0]  frame_length;
      logic [BYTE_W-1:0]    payload_byte;
      logic [PERCENT_W-1:0] success_percent;
   } frame_result_type;

   typedef enum logic [2:0] {
      HUNT_TAG, TAKE_ID, TAKE_LEN, TAKE_DATA, TAKE_SUM, FRAME_END
   } link_phase_type;

   typedef enum int {
      FLAW_NONE, FLAW_SUM, FLAW_ESCAPE, FLAW_OVERSIZE, FLAW_SPIN, FLAW_HIGH
   } frame_flaw_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [BYTE_W-1:0] csr_wr_data = '0;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();

   stuffed_frame_receiver DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .rsp         (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser shadow state
   logic [BYTE_W-1:0]    tag_q = TAG_RESET;
   link_phase_type       link_phase = HUNT_TAG;
   logic                 escape_seen = 1'b0;
   logic [BYTE_W-1:0]    ident_q = '0;
   int                   len_q = 0;
   int                   group_idx = 0;
   int                   data_idx = 0;
   logic [BYTE_W-1:0]    check_sum = '0;
   logic [BYTE_W-1:0]    payload_mem [PAYLOAD_DEPTH];
   int                   good_frames = 0;
   int                   bad_frames = 0;
   logic [PERCENT_W-1:0] rate_q = '0;

   // Stimulus and scoreboard
   link_item_type     pending_items[$];
   frame_result_type  expected_results[$];
   link_item_type     in_flight;
   logic [BYTE_W-1:0] link_tag = TAG_RESET;
   int                queued_count = 0;
   int                result_count = 0;
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   bit                mix_reads = 1'b0;

   task automatic drop_to_hunt();
      link_phase = HUNT_TAG;
      escape_seen = 1'b0;
      group_idx = 0;
      data_idx = 0;
      check_sum = '0;
   endtask

   // Advance the parser by one item and form its result
   task automatic parse_link_item(input link_item_type it, output frame_result_type res);
      logic [BYTE_W-1:0] b;
      int                widened;
      bit                in_frame, good, bad, halt;
      b = it.rx_byte;
      good = 1'b0;
      bad = 1'b0;
      halt = 1'b0;
      if (it.opcode == OPCODE_RX) begin
         if (link_phase == FRAME_END) drop_to_hunt();
         in_frame = (link_phase == TAKE_ID) || (link_phase == TAKE_LEN) ||
                    (link_phase == TAKE_DATA) || (link_phase == TAKE_SUM);
         if (!in_frame) begin
            // hunt for two tags in a row
            if (b != tag_q) begin
               escape_seen = 1'b0;
            end else if (escape_seen) begin
               link_phase = TAKE_ID;
               escape_seen = 1'b0;
               len_q = 0;
            end else begin
               escape_seen = 1'b1;
            end
         end else if (escape_seen) begin
            // a tag inside a frame must be followed by a stuffed zero
            if (b == 8'h00) escape_seen = 1'b0;
            else bad = 1'b1;
         end else begin
            if (b == tag_q) escape_seen = 1'b1;
            case (link_phase)
               TAKE_ID: begin
                  check_sum += b;
                  ident_q = b;
                  link_phase = TAKE_LEN;
               end
               TAKE_LEN: begin
                  check_sum += b;
                  if (b[6:0] != 7'd0) begin
                     if (group_idx >= SUMMED_GROUPS) begin
                        halt = 1'b1;
                     end else begin
                        widened = len_q + (int'(b[6:0]) << (GROUP_BITS * group_idx));
                        if (widened > PAYLOAD_DEPTH) halt = 1'b1;
                        else len_q = widened;
                     end
                  end
                  if (halt) begin
                     bad = 1'b1;
                  end else if (!b[7]) begin
                     if (len_q == 0) link_phase = TAKE_SUM;
                     else link_phase = TAKE_DATA;
                  end else if (group_idx >= LAST_GROUP) begin
                     bad = 1'b1;
                  end else begin
                     group_idx++;
                  end
               end
               TAKE_DATA: begin
                  check_sum += b;
                  if (data_idx < PAYLOAD_DEPTH) payload_mem[data_idx] = b;
                  data_idx++;
                  if (data_idx >= len_q) begin
                     link_phase = TAKE_SUM;
                     data_idx = 0;
                  end
               end
               default: begin
                  if (b != check_sum) begin
                     bad = 1'b1;
                  end else begin
                     good = 1'b1;
                     link_phase = FRAME_END;
                     good_frames = (good_frames + 1) % 16;
                  end
               end
            endcase
         end
         if (bad) begin
            bad_frames = (bad_frames + 1) % 16;
            drop_to_hunt();
            len_q = 0;
         end
         // latch the success rate every ten finished frames
         if (good_frames + bad_frames >= FRAMES_PER_RATE) begin
            rate_q = PERCENT_W'(good_frames * 10);
            good_frames = 0;
            bad_frames = 0;
         end
      end
      res.frame_good = good;
      res.frame_error = bad;
      res.frame_ident = ident_q;
      res.frame_length = LENGTH_W'(len_q);
      if (int'(it.read_index) < len_q && int'(it.read_index) < PAYLOAD_DEPTH)
         res.payload_byte = payload_mem[it.read_index];
      else
         res.payload_byte = 8'h00;
      res.success_percent = rate_q;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               result_count, what, got, want);
   endtask

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(0, 63));
   endfunction

   task automatic queue_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] ri);
      link_item_type it;
      it.opcode = op;
      it.rx_byte = b;
      it.read_index = ri;
      pending_items.push_back(it);
      queued_count++;
   endtask

   // Queue one frame body byte, stuffing a zero after a tag value; with mix_reads, a random read may go ahead of it
   task automatic queue_body_byte(input logic [BYTE_W-1:0] b, input logic [INDEX_W-1:0] ri);
      if (mix_reads && $urandom_range(0, 99) < 6)
         queue_item(OPCODE_READ, BYTE_W'($urandom_range(0, 255)), any_index());
      queue_item(OPCODE_RX, b, ri);
      if (b == link_tag) queue_item(OPCODE_RX, 8'h00, ri);
   endtask

   task automatic emit_frame(input logic [BYTE_W-1:0] ident, input int len, input int pad,
                             input frame_flaw_type flaw, input bit stuff_sum);
      logic [BYTE_W-1:0] sum, lb, b;
      int                g, i, hi_pos, esc_at, groups;
      sum = ident;
      hi_pos = $urandom_range(1, 2);
      esc_at = $urandom_range(0, len);
      groups = pad;
      if (flaw == FLAW_SPIN) groups = 8;
      if (flaw == FLAW_HIGH && groups < 3) groups = 3;
      queue_item(OPCODE_RX, link_tag, any_index());
      queue_item(OPCODE_RX, link_tag, any_index());
      queue_body_byte(ident, any_index());
      // length groups, padded with zero continuation groups
      for (g = 0; g <= groups; g++) begin
         lb = (g == 0) ? BYTE_W'(len) & 8'h7F : 8'h00;
         if (flaw == FLAW_OVERSIZE && g == 0) lb = BYTE_W'($urandom_range(65, 127));
         if (flaw == FLAW_HIGH && g == hi_pos) lb = BYTE_W'($urandom_range(1, 127));
         if (g < groups) lb[7] = 1'b1;
         queue_body_byte(lb, any_index());
         sum += lb;
      end
      for (i = 0; i <= len; i++) begin
         if (flaw == FLAW_ESCAPE && i == esc_at) begin
            // tag followed by something other than the stuffed zero
            queue_item(OPCODE_RX, link_tag, any_index());
            queue_item(OPCODE_RX, BYTE_W'($urandom_range(1, 255)), any_index());
         end
         if (i < len) begin
            b = ($urandom_range(0, 4) == 0) ? link_tag : BYTE_W'($urandom_range(0, 255));
            queue_body_byte(b, any_index());
            sum += b;
         end
      end
      if (flaw == FLAW_SUM) sum += BYTE_W'($urandom_range(1, 255));
      queue_item(OPCODE_RX, sum, any_index());
      if (sum == link_tag && stuff_sum) queue_item(OPCODE_RX, 8'h00, any_index());
   endtask

   // Fill every payload entry before any free read: a 63-byte frame, then a 64-byte one
   task automatic prime_store();
      logic [BYTE_W-1:0]  sum, b;
      logic [INDEX_W-1:0] ri;
      int                 len, i;
      for (int pass = 0; pass < 2; pass++) begin
         len = (pass == 0) ? 63 : 64;
         ri = (pass == 0) ? 6'd63 : 6'd0;
         sum = BYTE_W'(len);
         queue_item(OPCODE_RX, link_tag, ri);
         queue_item(OPCODE_RX, link_tag, ri);
         queue_body_byte(8'h00, ri);
         queue_body_byte(BYTE_W'(len), ri);
         for (i = 0; i < len; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            queue_body_byte(b, ri);
            sum += b;
            ri = 6'd0;
         end
         queue_body_byte(sum, 6'd0);
      end
   endtask

   task automatic run_directed();
      queue_item(OPCODE_READ, 8'h00, 6'd0);
      queue_item(OPCODE_READ, 8'hFF, 6'd63);
      // empty frame whose checksum equals the tag, next start right behind it
      emit_frame(link_tag, 0, 0, FLAW_NONE, 1'b0);
      // length carried with zero continuation groups
      emit_frame(8'h00, 1, 2, FLAW_NONE, 1'b1);
      emit_frame(8'h05, 2, 0, FLAW_ESCAPE, 1'b1);
      emit_frame(8'h10, 0, 0, FLAW_OVERSIZE, 1'b0);
      emit_frame(8'h7F, 0, 0, FLAW_SUM, 1'b0);
   endtask

   // Mostly well-formed frames, with noise bytes, reads and broken frames mixed in
   task automatic emit_random(input int n);
      int             start, pick, i, cnt, len, pad;
      frame_flaw_type flaw;
      start = queued_count;
      while (queued_count - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 13))
               0: flaw = FLAW_SUM;
               1: flaw = FLAW_ESCAPE;
               2: flaw = FLAW_OVERSIZE;
               3: flaw = FLAW_SPIN;
               4: flaw = FLAW_HIGH;
               default: flaw = FLAW_NONE;
            endcase
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 10);
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
            emit_frame(BYTE_W'($urandom_range(0, 255)), len, pad, flaw,
                       1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            cnt = $urandom_range(1, 6);
            for (i = 0; i < cnt; i++)
               queue_item(OPCODE_RX, $urandom_range(0, 1) ? link_tag :
                          BYTE_W'($urandom_range(0, 255)), any_index());
         end else begin
            cnt = $urandom_range(1, 4);
            for (i = 0; i < cnt; i++)
               queue_item(OPCODE_READ, BYTE_W'($urandom_range(0, 255)), any_index());
         end
      end
   endtask

   task automatic write_tag(input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tag_q = value;
      link_tag = value;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Drive request items and predict each one as it is accepted
   always @(posedge clock) begin : drive_link
      frame_result_type want;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_link_item(in_flight, want);
            expected_results.push_back(want);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = pending_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.opcode <= in_flight.opcode;
               req_bus.rx_byte <= in_flight.rx_byte;
               req_bus.read_index <= in_flight.read_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Take results and compare them with the oldest prediction
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.frame_good !== want.frame_good)
                  report_mismatch("frame_good", 32'(rsp_bus.frame_good),
                                  32'(want.frame_good));
               if (rsp_bus.frame_error !== want.frame_error)
                  report_mismatch("frame_error", 32'(rsp_bus.frame_error),
                                  32'(want.frame_error));
               if (rsp_bus.frame_ident !== want.frame_ident)
                  report_mismatch("frame_ident", 32'(rsp_bus.frame_ident),
                                  32'(want.frame_ident));
               if (rsp_bus.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(rsp_bus.frame_length),
                                  32'(want.frame_length));
               if (rsp_bus.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(rsp_bus.payload_byte),
                                  32'(want.payload_byte));
               if (rsp_bus.success_percent !== want.success_percent)
                  report_mismatch("success_percent", 32'(rsp_bus.success_percent),
                                  32'(want.success_percent));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin : run_test
      logic [BYTE_W-1:0] next_tag;
      int                seg;
      req_bus.valid = 1'b0;
      req_bus.opcode = OPCODE_RX;
      req_bus.rx_byte = '0;
      req_bus.read_index = '0;
      rsp_bus.ready = 1'b0;
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (seg = 0; seg < 8; seg++) begin
         // rotate through the idling patterns
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         case (seg)
            0, 7: next_tag = 8'hFF;
            1: next_tag = 8'h00;
            3: next_tag = 8'h7F;
            4: next_tag = 8'h80;
            default: next_tag = BYTE_W'($urandom_range(0, 255));
         endcase
         write_tag(next_tag);
         if (seg == 0) begin
            prime_store();
            run_directed();
            mix_reads = 1'b1;
         end
         emit_random(75);
         wait_drained();
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_back.sv
hw/rtl/stuffed_frame_receiver.sv
tb/stuffed_frame_receiver_tb.sv
